// ----- design/cbft_pkg.sv -----
// ----------------------------------------------------------------------------
// Frame transmitter package
// Shared types, constants and helper functions of the CRC-32C / base64 serial
// frame transmitter.
// ----------------------------------------------------------------------------
package cbft_pkg;

  localparam int MAX_FRAME_BYTES = 4096;
  localparam int FRAME_LEN_LIMIT = MAX_FRAME_BYTES - 12;
  localparam int LEN_W           = 12;

  localparam logic [7:0] PREAMBLE_BYTE = 8'hFF;
  localparam logic [7:0] STX_BYTE      = 8'h02;
  localparam logic [7:0] ETX_BYTE      = 8'h03;
  localparam logic [7:0] PAD_BYTE      = 8'h3D;

  localparam logic [31:0] CRC_POLY = 32'h82F63B78;
  localparam logic [31:0] CRC_INIT = 32'hFFFFFFFF;

  localparam logic OP_START = 1'b0;
  localparam logic OP_DATA  = 1'b1;

  localparam int CMD_DEPTH = 4;
  localparam int CMD_PTR_W = $clog2(CMD_DEPTH);
  localparam int CMD_CNT_W = $clog2(CMD_DEPTH + 1);

  typedef enum logic {
    CMD_START = 1'b0,
    CMD_DATA  = 1'b1
  } cmd_kind_e;

  typedef struct packed {
    logic              op;
    logic [31:0]       message_number;
    logic [LEN_W-1:0]  payload_length;
    logic [7:0]        data_byte;
  } in_item_t;

  typedef struct packed {
    logic [7:0] out_byte;
    logic       run_last;
    logic       frame_end;
  } out_item_t;

  typedef struct packed {
    cmd_kind_e         kind;
    logic              fin;
    logic [31:0]       msg;
    logic [LEN_W-1:0]  len;
    logic [7:0]        data;
  } cmd_t;

  function automatic logic [7:0] b64_char(input logic [5:0] v);
    logic [7:0] c;
    if (v inside {[6'd0:6'd25]}) begin
      c = 8'h41 + {2'b00, v};
    end else if (v inside {[6'd26:6'd51]}) begin
      c = 8'h61 + {2'b00, v} - 8'd26;
    end else if (v inside {[6'd52:6'd61]}) begin
      c = 8'h30 + {2'b00, v} - 8'd52;
    end else if (v == 6'd62) begin
      c = 8'h2B;
    end else begin
      c = 8'h2F;
    end
    return c;
  endfunction

  function automatic logic [31:0] crc32c_byte(input logic [31:0] crc, input logic [7:0] b);
    logic [31:0] c;
    c = crc ^ {24'h000000, b};
    for (int k = 0; k < 8; k++) begin
      c = c[0] ? ((c >> 1) ^ CRC_POLY) : (c >> 1);
    end
    return c;
  endfunction

endpackage

// ----- design/cbft_front.sv -----
// ----------------------------------------------------------------------------
// Frame transmitter front end
// Accepts input transactions, tracks the open frame and the payload bytes
// still expected; starts and in-frame data become commands for the encoder.
// ----------------------------------------------------------------------------
module cbft_front (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              in_valid_i,
  input  cbft_pkg::in_item_t in_item_i,
  output logic              cmd_push_o,
  output cbft_pkg::cmd_t    cmd_o
);

  logic                        in_frame_q, in_frame_d;
  logic [cbft_pkg::LEN_W-1:0]  remain_q, remain_d;
  logic [cbft_pkg::LEN_W-1:0]  len_sat;

  always_comb begin
    if (32'(in_item_i.payload_length) > 32'(cbft_pkg::FRAME_LEN_LIMIT)) begin
      len_sat = cbft_pkg::LEN_W'(cbft_pkg::FRAME_LEN_LIMIT);
    end else begin
      len_sat = in_item_i.payload_length;
    end
  end

  always_comb begin
    in_frame_d = in_frame_q;
    remain_d   = remain_q;
    cmd_push_o = 1'b0;
    cmd_o.kind = cbft_pkg::CMD_START;
    cmd_o.fin  = 1'b0;
    cmd_o.msg  = in_item_i.message_number;
    cmd_o.len  = len_sat;
    cmd_o.data = in_item_i.data_byte;
    if (in_valid_i) begin
      if (in_item_i.op == cbft_pkg::OP_START) begin
        cmd_push_o = 1'b1;
        cmd_o.fin  = (len_sat == '0);
        in_frame_d = (len_sat != '0);
        remain_d   = len_sat;
      end else if (in_frame_q) begin
        cmd_push_o = 1'b1;
        cmd_o.kind = cbft_pkg::CMD_DATA;
        cmd_o.fin  = (remain_q == cbft_pkg::LEN_W'(1));
        in_frame_d = (remain_q != cbft_pkg::LEN_W'(1));
        remain_d   = remain_q - cbft_pkg::LEN_W'(1);
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_frame_q <= 1'b0;
      remain_q   <= '0;
    end else begin
      in_frame_q <= in_frame_d;
      remain_q   <= remain_d;
    end
  end

endmodule

// ----- design/cbft_cmd_queue.sv -----
// ----------------------------------------------------------------------------
// Frame transmitter command queue
// Short first-in first-out buffer that decouples the front end from the
// encoder.
// ----------------------------------------------------------------------------
module cbft_cmd_queue (
  input  logic           clk_i,
  input  logic           rst_ni,
  input  logic           push_i,
  input  cbft_pkg::cmd_t cmd_i,
  output logic           full_o,
  input  logic           pop_i,
  output logic           empty_o,
  output cbft_pkg::cmd_t cmd_o
);

  cbft_pkg::cmd_t                   mem_q [cbft_pkg::CMD_DEPTH];
  logic [cbft_pkg::CMD_PTR_W-1:0]   wr_q, rd_q;
  logic [cbft_pkg::CMD_CNT_W-1:0]   cnt_q;
  logic                             do_push, do_pop;

  assign full_o  = (cnt_q == cbft_pkg::CMD_CNT_W'(cbft_pkg::CMD_DEPTH));
  assign empty_o = (cnt_q == '0);
  assign do_push = push_i && !full_o;
  assign do_pop  = pop_i && !empty_o;
  assign cmd_o   = mem_q[rd_q];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_q  <= '0;
      rd_q  <= '0;
      cnt_q <= '0;
    end else begin
      if (do_push) begin
        wr_q <= (wr_q == cbft_pkg::CMD_PTR_W'(cbft_pkg::CMD_DEPTH - 1)) ? '0 : wr_q + 1'b1;
      end
      if (do_pop) begin
        rd_q <= (rd_q == cbft_pkg::CMD_PTR_W'(cbft_pkg::CMD_DEPTH - 1)) ? '0 : rd_q + 1'b1;
      end
      if (do_push && !do_pop) begin
        cnt_q <= cnt_q + 1'b1;
      end else if (do_pop && !do_push) begin
        cnt_q <= cnt_q - 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (do_push) begin
      mem_q[wr_q] <= cmd_i;
    end
  end

endmodule

// ----- design/cbft_back.sv -----
// ----------------------------------------------------------------------------
// Frame transmitter encoder
// Carries out commands: emits preamble and STX, runs the CRC-32C one byte per
// cycle while the output buffer has room, base64-encodes header, payload and CRC,
// and closes the frame with ETX. Results leave through a two-entry output buffer.
// ----------------------------------------------------------------------------
module cbft_back (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                cmd_valid_i,
  input  cbft_pkg::cmd_t      cmd_i,
  output logic                cmd_pop_o,
  input  logic                pop_i,
  output logic                empty_o,
  output cbft_pkg::out_item_t res_o
);

  localparam logic [2:0] S_IDLE  = 3'd0;
  localparam logic [2:0] S_PRE   = 3'd1;
  localparam logic [2:0] S_HDR   = 3'd2;
  localparam logic [2:0] S_CHR   = 3'd3;
  localparam logic [2:0] S_ZERO  = 3'd4;
  localparam logic [2:0] S_CRC   = 3'd5;
  localparam logic [2:0] S_FLUSH = 3'd6;
  localparam logic [2:0] S_ETX   = 3'd7;

  logic [2:0]          state_q, state_d, ret_q, ret_d, nxt;
  logic [2:0]          idx_q, idx_d;
  logic [1:0]          chr_q, chr_d;
  logic [2:0]          nval_q, nval_d;
  logic [23:0]         grp_q, grp_d;
  logic [15:0]         pend_q, pend_d;
  logic [1:0]          pcnt_q, pcnt_d;
  logic [31:0]         crc_q, crc_d, crc_nxt, crc_inv;
  cbft_pkg::cmd_t      cmd_q, cmd_d;
  logic [7:0]          cb, fb;
  logic                do_push;
  logic [63:0]         hdr_word;
  logic [5:0]          six;
  logic                emit;
  cbft_pkg::out_item_t res;

  cbft_pkg::out_item_t ob_q [2];
  logic                ob_wr_q, ob_rd_q;
  logic [1:0]          ob_cnt_q;
  logic                out_ok, ob_pop;

  assign out_ok   = (ob_cnt_q != 2'd2);
  assign ob_pop   = pop_i && (ob_cnt_q != 2'd0);
  assign empty_o  = (ob_cnt_q == 2'd0);
  assign res_o    = ob_q[ob_rd_q];
  assign crc_nxt  = cbft_pkg::crc32c_byte(crc_q, cb);
  assign crc_inv  = ~crc_q;
  assign hdr_word = {20'h00000, cmd_q.len, cmd_q.msg};

  always_comb begin
    case (chr_q)
      2'd0:    six = grp_q[23:18];
      2'd1:    six = grp_q[17:12];
      2'd2:    six = grp_q[11:6];
      default: six = grp_q[5:0];
    endcase
  end

  always_comb begin
    state_d   = state_q;
    ret_d     = ret_q;
    idx_d     = idx_q;
    chr_d     = chr_q;
    nval_d    = nval_q;
    grp_d     = grp_q;
    pend_d    = pend_q;
    pcnt_d    = pcnt_q;
    crc_d     = crc_q;
    cmd_d     = cmd_q;
    cb        = 8'h00;
    fb        = 8'h00;
    do_push   = 1'b0;
    nxt       = state_q;
    emit      = 1'b0;
    res       = '0;
    cmd_pop_o = 1'b0;

    if (out_ok) begin
      case (state_q)
        S_IDLE: begin
          if (cmd_valid_i) begin
            cmd_pop_o = 1'b1;
            cmd_d     = cmd_i;
            if (cmd_i.kind == cbft_pkg::CMD_START) begin
              crc_d        = cbft_pkg::CRC_INIT;
              pend_d       = 16'h0000;
              pcnt_d       = 2'd0;
              emit         = 1'b1;
              res.out_byte = cbft_pkg::PREAMBLE_BYTE;
              idx_d        = 3'd1;
              state_d      = S_PRE;
            end else begin
              cb      = cmd_i.data;
              crc_d   = crc_nxt;
              fb      = cmd_i.data;
              do_push = 1'b1;
              nxt     = cmd_i.fin ? S_ZERO : S_IDLE;
              idx_d   = 3'd0;
            end
          end
        end
        S_PRE: begin
          emit = 1'b1;
          if (idx_q == 3'd2) begin
            res.out_byte = cbft_pkg::STX_BYTE;
            idx_d        = 3'd0;
            state_d      = S_HDR;
          end else begin
            res.out_byte = cbft_pkg::PREAMBLE_BYTE;
            idx_d        = idx_q + 3'd1;
          end
        end
        S_HDR: begin
          cb      = hdr_word[{idx_q, 3'b000} +: 8];
          crc_d   = crc_nxt;
          fb      = cb;
          do_push = 1'b1;
          if (idx_q == 3'd7) begin
            nxt   = cmd_q.fin ? S_ZERO : S_IDLE;
            idx_d = 3'd0;
          end else begin
            nxt   = S_HDR;
            idx_d = idx_q + 3'd1;
          end
        end
        S_CHR: begin
          emit         = 1'b1;
          res.out_byte = ({1'b0, chr_q} < nval_q) ? cbft_pkg::b64_char(six)
                                                  : cbft_pkg::PAD_BYTE;
          chr_d        = chr_q + 2'd1;
          if (chr_q == 2'd3) begin
            state_d      = ret_q;
            res.run_last = (ret_q == S_IDLE) ||
                           ((ret_q == S_HDR) && (idx_q == 3'd6) && !cmd_q.fin);
          end
        end
        S_ZERO: begin
          cb    = 8'h00;
          crc_d = crc_nxt;
          if (idx_q == 3'd3) begin
            idx_d   = 3'd0;
            state_d = S_CRC;
          end else begin
            idx_d = idx_q + 3'd1;
          end
        end
        S_CRC: begin
          fb      = crc_inv[{idx_q[1:0], 3'b000} +: 8];
          do_push = 1'b1;
          if (idx_q == 3'd3) begin
            nxt   = S_FLUSH;
            idx_d = 3'd0;
          end else begin
            nxt   = S_CRC;
            idx_d = idx_q + 3'd1;
          end
        end
        S_FLUSH: begin
          if (pcnt_q == 2'd0) begin
            state_d = S_ETX;
          end else begin
            emit         = 1'b1;
            res.out_byte = cbft_pkg::b64_char(pend_q[15:10]);
            grp_d        = {pend_q, 8'h00};
            nval_d       = {1'b0, pcnt_q} + 3'd1;
            chr_d        = 2'd1;
            ret_d        = S_ETX;
            state_d      = S_CHR;
            pend_d       = 16'h0000;
            pcnt_d       = 2'd0;
          end
        end
        S_ETX: begin
          emit          = 1'b1;
          res.out_byte  = cbft_pkg::ETX_BYTE;
          res.run_last  = 1'b1;
          res.frame_end = 1'b1;
          crc_d         = cbft_pkg::CRC_INIT;
          state_d       = S_IDLE;
        end
        default: begin
          state_d = S_IDLE;
        end
      endcase

      if (do_push) begin
        case (pcnt_q)
          2'd0: begin
            pend_d  = {fb, 8'h00};
            pcnt_d  = 2'd1;
            state_d = nxt;
          end
          2'd1: begin
            pend_d  = {pend_q[15:8], fb};
            pcnt_d  = 2'd2;
            state_d = nxt;
          end
          default: begin
            emit         = 1'b1;
            res.out_byte = cbft_pkg::b64_char(pend_q[15:10]);
            grp_d        = {pend_q, fb};
            nval_d       = 3'd4;
            chr_d        = 2'd1;
            ret_d        = nxt;
            state_d      = S_CHR;
            pend_d       = 16'h0000;
            pcnt_d       = 2'd0;
          end
        endcase
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q  <= S_IDLE;
      ret_q    <= S_IDLE;
      idx_q    <= 3'd0;
      chr_q    <= 2'd0;
      nval_q   <= 3'd4;
      pend_q   <= 16'h0000;
      pcnt_q   <= 2'd0;
      crc_q    <= cbft_pkg::CRC_INIT;
      ob_wr_q  <= 1'b0;
      ob_rd_q  <= 1'b0;
      ob_cnt_q <= 2'd0;
    end else begin
      state_q <= state_d;
      ret_q   <= ret_d;
      idx_q   <= idx_d;
      chr_q   <= chr_d;
      nval_q  <= nval_d;
      pend_q  <= pend_d;
      pcnt_q  <= pcnt_d;
      crc_q   <= crc_d;
      if (emit) begin
        ob_wr_q <= ~ob_wr_q;
      end
      if (ob_pop) begin
        ob_rd_q <= ~ob_rd_q;
      end
      if (emit && !ob_pop) begin
        ob_cnt_q <= ob_cnt_q + 2'd1;
      end else if (ob_pop && !emit) begin
        ob_cnt_q <= ob_cnt_q - 2'd1;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    grp_q <= grp_d;
    cmd_q <= cmd_d;
    if (emit) begin
      ob_q[ob_wr_q] <= res;
    end
  end

endmodule

// ----- design/crc_base64_frame_transmitter.sv -----
// ----------------------------------------------------------------------------
// CRC-32C protected base64 serial frame transmitter
// A data transaction occupies the encoder longer when it completes a base64 group,
// as the four characters of that group are then emitted.
// The first result passes through the command queue and the output buffer.
// Reset clears the queues, the frame tracking and the encoder, which then idles.
// ----------------------------------------------------------------------------
module crc_base64_frame_transmitter (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                push,
  output logic                full,
  input  cbft_pkg::in_item_t  in_item_i,
  output logic                empty,
  input  logic                pop,
  output cbft_pkg::out_item_t out_item_o
);

  logic           in_valid;
  logic           cmd_push, cmd_pop, cmd_empty;
  cbft_pkg::cmd_t cmd_in, cmd_out;

  assign in_valid = push && !full;

  cbft_front u_front (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid),
    .in_item_i  (in_item_i),
    .cmd_push_o (cmd_push),
    .cmd_o      (cmd_in)
  );

  cbft_cmd_queue u_cmd_queue (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (cmd_push),
    .cmd_i   (cmd_in),
    .full_o  (full),
    .pop_i   (cmd_pop),
    .empty_o (cmd_empty),
    .cmd_o   (cmd_out)
  );

  cbft_back u_back (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cmd_valid_i (!cmd_empty),
    .cmd_i       (cmd_out),
    .cmd_pop_o   (cmd_pop),
    .pop_i       (pop),
    .empty_o     (empty),
    .res_o       (out_item_o)
  );

endmodule

// ----- test/tb.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Frame transmitter testbench
// Drives start and payload transactions into the frame transmitter and checks
// every output byte against a local prediction of the preamble, base64 text,
// CRC-32C tail and ETX, with random idling on both sides of the block.
// ----------------------------------------------------------------------------
module tb;
  import cbft_pkg::*;

  localparam int RANDOM_ITEMS   = 200;
  localparam int CALM_ITEMS     = 40;
  localparam int HOLD_AFTER     = 200;
  localparam int HOLD_CYCLES    = 300;
  localparam int WATCHDOG_LIMIT = 4000;
  localparam int TAIL_CYCLES    = 40;

  typedef struct packed {
    in_item_t item;
    logic     wait_drain;
  } stim_t;

  logic      clk_i  = 1'b0;
  logic      rst_ni = 1'b0;
  logic      push   = 1'b0;
  logic      full;
  in_item_t  in_item_i = '0;
  logic      empty;
  logic      pop    = 1'b0;
  out_item_t out_item_o;

  crc_base64_frame_transmitter i_dut (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .push       (push),
    .full       (full),
    .in_item_i  (in_item_i),
    .empty      (empty),
    .pop        (pop),
    .out_item_o (out_item_o)
  );

  stim_t     pending_items[$];
  out_item_t expected_bytes[$];
  out_item_t step_out[$];

  string b64_alphabet = "ABCDEFGHIJKLMNOPQRSTUVWXYZabcdefghijklmnopqrstuvwxyz0123456789+/";

  logic [31:0] model_crc  = CRC_INIT;
  logic [15:0] grp_bytes  = '0;
  logic [1:0]  grp_cnt    = '0;
  logic [12:0] bytes_left = '0;
  logic        framing    = 1'b0;

  logic      calm = 1'b0;
  int        send_gap = 0;
  int        recv_gap = 0;
  int        hold_cycles = 0;
  logic      hold_done = 1'b0;
  int        results_seen = 0;
  int        mismatches = 0;
  int        quiet_cycles = 0;
  stim_t     cur_stim;
  out_item_t want;

  function automatic logic [31:0] crc32c_update(input logic [31:0] c, input logic [7:0] b);
    logic [31:0] r;
    logic        fb;
    r = c;
    for (int k = 0; k < 8; k++) begin
      fb = r[0] ^ b[k];
      r  = r >> 1;
      if (fb) begin
        r = r ^ CRC_POLY;
      end
    end
    return r;
  endfunction

  task automatic emit_byte(input logic [7:0] b, input logic is_end);
    out_item_t o;
    o.out_byte  = b;
    o.run_last  = 1'b0;
    o.frame_end = is_end;
    step_out.push_back(o);
  endtask

  task automatic emit_symbol(input logic [5:0] v);
    emit_byte(b64_alphabet[v], 1'b0);
  endtask

  task automatic b64_feed(input logic [7:0] b);
    logic [23:0] grp;
    case (grp_cnt)
      2'd0: begin
        grp_bytes = {b, 8'h00};
        grp_cnt   = 2'd1;
      end
      2'd1: begin
        grp_bytes[7:0] = b;
        grp_cnt        = 2'd2;
      end
      default: begin
        grp = {grp_bytes, b};
        emit_symbol(grp[23:18]);
        emit_symbol(grp[17:12]);
        emit_symbol(grp[11:6]);
        emit_symbol(grp[5:0]);
        grp_bytes = '0;
        grp_cnt   = 2'd0;
      end
    endcase
  endtask

  task automatic b64_finish();
    logic [23:0] grp;
    grp = {grp_bytes, 8'h00};
    if (grp_cnt == 2'd1) begin
      emit_symbol(grp[23:18]);
      emit_symbol(grp[17:12]);
      emit_byte(PAD_BYTE, 1'b0);
      emit_byte(PAD_BYTE, 1'b0);
    end else if (grp_cnt == 2'd2) begin
      emit_symbol(grp[23:18]);
      emit_symbol(grp[17:12]);
      emit_symbol(grp[11:6]);
      emit_byte(PAD_BYTE, 1'b0);
    end
    grp_bytes = '0;
    grp_cnt   = 2'd0;
  endtask

  task automatic feed_byte(input logic [7:0] b);
    model_crc = crc32c_update(model_crc, b);
    b64_feed(b);
  endtask

  task automatic close_frame();
    logic [31:0] crc;
    for (int k = 0; k < 4; k++) begin
      model_crc = crc32c_update(model_crc, 8'h00);
    end
    crc = ~model_crc;
    for (int k = 0; k < 4; k++) begin
      b64_feed(crc[8*k +: 8]);
    end
    b64_finish();
    emit_byte(ETX_BYTE, 1'b1);
    model_crc  = CRC_INIT;
    bytes_left = '0;
    framing    = 1'b0;
  endtask

  task automatic predict_frame_bytes(input in_item_t it);
    logic [31:0] len32;
    out_item_t   o;
    step_out.delete();
    if (it.op == OP_START) begin
      len32 = {20'd0, it.payload_length};
      if (len32 > FRAME_LEN_LIMIT) begin
        len32 = FRAME_LEN_LIMIT;
      end
      model_crc  = CRC_INIT;
      grp_bytes  = '0;
      grp_cnt    = 2'd0;
      framing    = 1'b1;
      bytes_left = len32[12:0];
      emit_byte(PREAMBLE_BYTE, 1'b0);
      emit_byte(PREAMBLE_BYTE, 1'b0);
      emit_byte(STX_BYTE, 1'b0);
      for (int k = 0; k < 4; k++) begin
        feed_byte(it.message_number[8*k +: 8]);
      end
      for (int k = 0; k < 4; k++) begin
        feed_byte(len32[8*k +: 8]);
      end
      if (bytes_left == 0) begin
        close_frame();
      end
    end else if (framing) begin
      feed_byte(it.data_byte);
      if (bytes_left != 0) begin
        bytes_left = bytes_left - 1'b1;
      end
      if (bytes_left == 0) begin
        close_frame();
      end
    end
    for (int i = 0; i < step_out.size(); i++) begin
      o = step_out[i];
      o.run_last = (i == step_out.size() - 1);
      expected_bytes.push_back(o);
    end
  endtask

  task automatic add_start(input logic [31:0] msg, input logic [LEN_W-1:0] len,
                           input logic drain);
    stim_t s;
    s.item.op             = OP_START;
    s.item.message_number = msg;
    s.item.payload_length = len;
    s.item.data_byte      = 8'($urandom_range(0, 255));
    s.wait_drain          = drain;
    pending_items.push_back(s);
  endtask

  task automatic add_data(input logic [7:0] b);
    stim_t s;
    s.item.op             = OP_DATA;
    s.item.message_number = $urandom();
    s.item.payload_length = LEN_W'($urandom_range(0, 4095));
    s.item.data_byte      = b;
    s.wait_drain          = 1'b0;
    pending_items.push_back(s);
  endtask

  initial begin
    forever #1 clk_i = ~clk_i;
  end

  always @(posedge clk_i) begin
    if (!rst_ni) begin
      push <= 1'b0;
    end else begin
      if (push && !full) begin
        predict_frame_bytes(in_item_i);
      end
      if (push && full) begin
        push <= 1'b1;
      end else if (send_gap > 0) begin
        send_gap = send_gap - 1;
        push <= 1'b0;
      end else if (pending_items.size() == 0) begin
        push <= 1'b0;
      end else if (pending_items[0].wait_drain && expected_bytes.size() != 0) begin
        push <= 1'b0;
      end else if (!calm && $urandom_range(0, 5) == 0) begin
        send_gap = $urandom_range(0, 5);
        push <= 1'b0;
      end else begin
        cur_stim = pending_items.pop_front();
        in_item_i <= cur_stim.item;
        push <= 1'b1;
      end
      calm <= (pending_items.size() < CALM_ITEMS);
    end
  end

  always @(posedge clk_i) begin
    if (!rst_ni) begin
      pop <= 1'b0;
    end else begin
      if (pop && !empty) begin
        if (expected_bytes.size() == 0) begin
          $display("%0t: unexpected transaction, actual byte %h last %b end %b", $time,
                   out_item_o.out_byte, out_item_o.run_last, out_item_o.frame_end);
          mismatches++;
        end else begin
          want = expected_bytes.pop_front();
          results_seen++;
          if (out_item_o.out_byte !== want.out_byte) begin
            $display("%0t: out_byte expected %h actual %h", $time, want.out_byte,
                     out_item_o.out_byte);
            mismatches++;
          end
          if (out_item_o.run_last !== want.run_last) begin
            $display("%0t: run_last expected %b actual %b", $time, want.run_last,
                     out_item_o.run_last);
            mismatches++;
          end
          if (out_item_o.frame_end !== want.frame_end) begin
            $display("%0t: frame_end expected %b actual %b", $time, want.frame_end,
                     out_item_o.frame_end);
            mismatches++;
          end
        end
      end
      if (hold_cycles > 0) begin
        hold_cycles = hold_cycles - 1;
        pop <= 1'b0;
      end else if (!hold_done && results_seen >= HOLD_AFTER) begin
        hold_done   = 1'b1;
        hold_cycles = HOLD_CYCLES - 1;
        pop <= 1'b0;
      end else if (recv_gap > 0) begin
        recv_gap = recv_gap - 1;
        pop <= 1'b0;
      end else if (!calm && $urandom_range(0, 5) == 0) begin
        recv_gap = $urandom_range(0, 5);
        pop <= 1'b0;
      end else begin
        pop <= 1'b1;
      end
    end
  end

  always @(posedge clk_i) begin
    if (rst_ni) begin
      if ((push && !full) || (pop && !empty)) begin
        quiet_cycles = 0;
      end else begin
        quiet_cycles = quiet_cycles + 1;
      end
      if (quiet_cycles >= WATCHDOG_LIMIT) begin
        $display("simulation failed");
        $finish;
      end
    end
  end

  initial begin
    int          random_items;
    int          sel;
    int          len;
    int          sent;
    logic        frame_open;
    logic        drain_placed;

    // Directed frames: stray data, zero length, padding cases, saturation, restarts.
    add_data(8'hAA);
    add_start(32'h0000_0000, 12'd0, 1'b0);
    add_start(32'hFFFF_FFFF, 12'd1, 1'b0);
    add_data(8'hFF);
    add_start(32'h1234_5678, 12'd2, 1'b0);
    add_data(8'h00);
    add_data(8'h80);
    add_start(32'hA5A5_A5A5, 12'd3, 1'b0);
    add_data(8'h01);
    add_data(8'h02);
    add_data(8'h03);
    add_data(8'h55);
    add_start(32'hDEAD_BEEF, 12'd4095, 1'b0);
    add_data(8'h7F);
    add_start(32'h0000_0001, 12'd4084, 1'b0);
    add_data(8'hFE);
    add_start(32'h0000_0002, 12'd0, 1'b0);

    random_items = 0;
    frame_open   = 1'b0;
    drain_placed = 1'b0;
    while (random_items < RANDOM_ITEMS) begin
      sel = $urandom_range(0, 19);
      if (sel == 0 && !frame_open) begin
        repeat ($urandom_range(1, 3)) add_data(8'($urandom_range(0, 255)));
      end else if (sel <= 2 && sel != 0) begin
        case ($urandom_range(0, 2))
          0: len = $urandom_range(1, 40);
          1: len = $urandom_range(FRAME_LEN_LIMIT + 1, 4095);
          default: len = FRAME_LEN_LIMIT;
        endcase
        sent = $urandom_range(0, (len - 1 < 8) ? len - 1 : 8);
        add_start($urandom(), LEN_W'(len), 1'b0);
        repeat (sent) add_data(8'($urandom_range(0, 255)));
        random_items += sent + 1;
        frame_open = 1'b1;
      end else begin
        len = ($urandom_range(0, 7) == 0) ? $urandom_range(13, 48) : $urandom_range(0, 12);
        add_start($urandom(), LEN_W'(len), (!drain_placed && random_items >= 120));
        if (random_items >= 120) begin
          drain_placed = 1'b1;
        end
        repeat (len) add_data(8'($urandom_range(0, 255)));
        random_items += len + 1;
        frame_open = 1'b0;
      end
    end

    repeat (2) @(posedge clk_i);
    rst_ni <= 1'b1;

    while (pending_items.size() != 0 || push) @(posedge clk_i);
    while (expected_bytes.size() != 0) @(posedge clk_i);
    repeat (TAIL_CYCLES) @(posedge clk_i);

    if (mismatches == 0) begin
      $display("simulation ok");
    end else begin
      $display("simulation failed");
    end
    $finish;
  end

endmodule

// ----- files.f -----
design/cbft_pkg.sv
design/cbft_front.sv
design/cbft_cmd_queue.sv
design/cbft_back.sv
design/crc_base64_frame_transmitter.sv
test/tb.sv
